### rtl/bsd_pkg.sv
package bsd_pkg;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SEXTET_PLUS       = 6'd62;
    localparam logic [5:0] SEXTET_SLASH      = 6'd63;

    localparam logic [1:0] POS_FULL = 2'd3;

    localparam logic [1:0] IDX_ONE   = 2'd0;
    localparam logic [1:0] IDX_TWO   = 2'd1;
    localparam logic [1:0] IDX_THREE = 2'd2;

    typedef enum logic [1:0] {
        K_SKIP,
        K_DATA,
        K_PAD
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [5:0] value;
    } t_class;

    // one queued transaction group: up to three results
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] last_idx;
        logic       has_byte;
        logic       last;
    } t_entry;

    function automatic t_class classify(input logic [7:0] c);
        t_class r;
        r.kind  = K_SKIP;
        r.value = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r.kind  = K_DATA;
            r.value = 6'(c - CHAR_UPPER_A);
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            r.kind  = K_DATA;
            r.value = 6'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
        end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            r.kind  = K_DATA;
            r.value = 6'(c - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE;
        end else if (c == CHAR_PLUS) begin
            r.kind  = K_DATA;
            r.value = SEXTET_PLUS;
        end else if (c == CHAR_SLASH) begin
            r.kind  = K_DATA;
            r.value = SEXTET_SLASH;
        end else if (c == CHAR_PAD) begin
            r.kind  = K_PAD;
        end
        return r;
    endfunction

endpackage

### rtl/bsd_front.sv
module bsd_front
    import bsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_text_char,
    input  logic       i_end_of_text,
    output logic       o_push,
    output t_entry     o_entry
);

    logic [1:0] r_pos, n_pos;
    logic [5:0] r_h0, n_h0;
    logic [5:0] r_h1, n_h1;
    logic [5:0] r_h2, n_h2;
    logic       r_term, n_term;
    t_class     cls;
    logic [7:0] first_b, second_b, third_b;

    assign cls      = classify(i_text_char);
    assign first_b  = {r_h0, r_h1[5:4]};
    assign second_b = {r_h1[3:0], r_h2[5:2]};
    assign third_b  = {r_h2[1:0], cls.value};

    always_comb begin
        n_pos   = r_pos;
        n_h0    = r_h0;
        n_h1    = r_h1;
        n_h2    = r_h2;
        n_term  = r_term;
        o_push  = 1'b0;
        o_entry = '0;
        if (i_accept) begin
            if (!r_term) begin
                case (cls.kind)
                    K_PAD: begin
                        o_push        = 1'b1;
                        o_entry.last  = 1'b1;
                        case (r_pos)
                            2'd0: begin
                                o_entry.has_byte = 1'b0;
                            end
                            POS_FULL: begin
                                o_entry.has_byte = 1'b1;
                                o_entry.b0       = first_b;
                                o_entry.b1       = second_b;
                                o_entry.last_idx = IDX_TWO;
                            end
                            default: begin
                                o_entry.has_byte = 1'b1;
                                o_entry.b0       = first_b;
                            end
                        endcase
                        n_term = 1'b1;
                    end
                    K_DATA: begin
                        case (r_pos)
                            2'd0: n_h0 = cls.value;
                            2'd1: n_h1 = cls.value;
                            2'd2: n_h2 = cls.value;
                            default: begin
                                o_push           = 1'b1;
                                o_entry.has_byte = 1'b1;
                                o_entry.b0       = first_b;
                                o_entry.b1       = second_b;
                                o_entry.b2       = third_b;
                                o_entry.last_idx = IDX_THREE;
                            end
                        endcase
                        n_pos = 2'(r_pos + 2'd1);
                    end
                    default: begin
                    end
                endcase
                // end of text closes the run with a last result
                if (i_end_of_text) begin
                    o_entry.last = 1'b1;
                    if (!o_push) begin
                        o_push           = 1'b1;
                        o_entry.has_byte = 1'b0;
                        o_entry.last_idx = IDX_ONE;
                    end
                end
            end
            if (i_end_of_text) begin
                n_pos  = '0;
                n_h0   = '0;
                n_h1   = '0;
                n_h2   = '0;
                n_term = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_h0   <= '0;
            r_h1   <= '0;
            r_h2   <= '0;
            r_term <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_h0   <= n_h0;
            r_h1   <= n_h1;
            r_h2   <= n_h2;
            r_term <= n_term;
        end
    end

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end_of_text) |=> (!r_term && r_pos == 2'd0))
        else $error("restart did not clear state");

    a_term_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_term |-> !o_push)
        else $error("results after pad");

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !o_entry.has_byte) |-> (o_entry.last && o_entry.last_idx == IDX_ONE))
        else $error("end marker malformed");

endmodule

### rtl/bsd_fifo.sv
module bsd_fifo
    import bsd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_head,
    output logic   o_head_valid,
    output logic   o_full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;

    assign o_head       = r_mem[r_rd];
    assign o_head_valid = (r_count != '0);
    assign o_full       = (r_count == CW'(DEPTH));

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr + 1'b1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : PW'(r_rd + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = CW'(r_count + 1'b1);
        end else if (!i_push && i_pop) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_head_valid |-> !i_pop)
        else $error("queue underflow");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("queue count mismatch");

endmodule

### rtl/bsd_back.sv
module bsd_back
    import bsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry     i_head,
    input  logic       i_head_valid,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_data_byte,
    output logic       o_byte_valid,
    output logic       o_last_of_run
);

    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_data, n_data;
    logic       r_bv, n_bv;
    logic       r_last, n_last;
    logic       load;
    logic       final_step;
    logic [7:0] sel_byte;

    assign load       = i_head_valid && (!r_out_valid || !i_stall);
    assign final_step = (r_idx == i_head.last_idx);
    assign o_pop      = load && final_step;

    always_comb begin
        case (r_idx)
            IDX_ONE: sel_byte = i_head.b0;
            IDX_TWO: sel_byte = i_head.b1;
            default: sel_byte = i_head.b2;
        endcase
    end

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_data      = r_data;
        n_bv        = r_bv;
        n_last      = r_last;
        if (load) begin
            n_out_valid = 1'b1;
            n_data      = sel_byte;
            n_bv        = i_head.has_byte;
            n_last      = i_head.last && final_step;
            n_idx       = final_step ? '0 : 2'(r_idx + 2'd1);
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_bv   <= n_bv;
        r_last <= n_last;
    end

    assign o_valid       = r_out_valid;
    assign o_data_byte   = r_data;
    assign o_byte_valid  = r_bv;
    assign o_last_of_run = r_last;

    a_mid_group_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> i_head_valid)
        else $error("partial group without queue head");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (r_idx <= i_head.last_idx))
        else $error("result index past group");

    a_marker_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_bv) |-> r_last)
        else $error("end marker not last");

endmodule

### rtl/base64_stream_decoder.sv
// base64 text decoder taking one character per transaction on the input side and
// giving one decoded byte (or end marker) per transaction on the output side. A
// character is accepted every cycle while the internal queue of QUEUE_DEPTH groups
// has room; a full four-character group gives three bytes, which leave through the
// single output register at one per cycle unless the receiver stalls, so dense
// text runs at one character per cycle, and only receiver stalls fill the queue
// and hold the input back. Each group is queued, and its results then pass through
// the output register. Non-alphabet characters are skipped, '=' ends decoding
// until the end-of-text character, and every run ends with a result flagged
// last_of_run.
module base64_stream_decoder
    import bsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_text_char,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_data_byte,
    output logic       o_byte_valid,
    output logic       o_last_of_run
);

    logic   accept;
    logic   push;
    logic   pop;
    logic   full;
    logic   head_valid;
    t_entry push_entry;
    t_entry head;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    bsd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_text_char   (i_text_char),
        .i_end_of_text (i_end_of_text),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    bsd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (push_entry),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_full       (full)
    );

    bsd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_head_valid  (head_valid),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_data_byte   (o_data_byte),
        .o_byte_valid  (o_byte_valid),
        .o_last_of_run (o_last_of_run)
    );

endmodule
